### design/hwg_pkg.sv
// package: shared types, constants and register map of the hand wave gesture detector
package hwg_pkg;

    localparam int COORD_BITS = 16;
    localparam int SHOULDER_SHIFT_DEF = 3;
    localparam int TIME_BITS = 32;
    localparam int COUNT_BITS = 5;
    localparam int MINSW_BITS = 4;
    localparam int GAP_BITS = 16;
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_ENABLE     = 2'd0;
    localparam logic [1:0] REG_MIN_SWINGS = 2'd1;
    localparam logic [1:0] REG_MAX_GAP    = 2'd2;

    localparam logic [MINSW_BITS-1:0] MIN_SWINGS_RST = 4'd6;
    localparam logic [GAP_BITS-1:0]   MAX_GAP_RST    = 16'd200;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [1:0] {
        SIDE_ORIGIN = 2'd0,
        SIDE_LEFT   = 2'd1,
        SIDE_RIGHT  = 2'd2
    } side_t;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_STARTED   = 2'd1,
        EV_COMPLETED = 2'd2,
        EV_CANCELLED = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        STEP_STARTED   = 2'd0,
        STEP_COMPLETED = 2'd1,
        STEP_CANCELLED = 2'd2
    } step_t;

    typedef struct packed {
        logic                 hand_select;
        coord_t               hand_x;
        coord_t               hand_y;
        logic                 hand_tracked;
        coord_t               elbow_y;
        coord_t               hip_y;
        coord_t               head_y;
        coord_t               left_shoulder_x;
        coord_t               right_shoulder_x;
        logic [TIME_BITS-1:0] time_now;
    } hwg_in_t;

    typedef struct packed {
        logic       event_hand;
        logic [1:0] event_step;
    } hwg_out_t;

    typedef struct packed {
        logic                  enable;
        logic [MINSW_BITS-1:0] min_swings;
        logic [GAP_BITS-1:0]   max_swing_gap;
    } hwg_cfg_t;

    typedef struct packed {
        logic                  in_position;
        side_t                 swing_side;
        logic [COUNT_BITS-1:0] swing_count;
        coord_t                last_hand_x;
        logic [TIME_BITS-1:0]  last_swing_time;
        event_t                last_event;
    } hwg_hand_t;

endpackage

### design/hwg_cfg.sv
// module: apb configuration registers of the hand wave gesture detector
module hwg_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hwg_pkg::ADDR_BITS-1:0] paddr,
    input  logic [hwg_pkg::DATA_BITS-1:0] pwdata,
    output logic [hwg_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    output hwg_pkg::hwg_cfg_t             cfg
);
    import hwg_pkg::*;

    hwg_cfg_t cfg_reg;
    hwg_cfg_t cfg_next;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                REG_ENABLE:     cfg_next.enable        = pwdata[0];
                REG_MIN_SWINGS: cfg_next.min_swings    = pwdata[MINSW_BITS-1:0];
                REG_MAX_GAP:    cfg_next.max_swing_gap = pwdata[GAP_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.min_swings    <= MIN_SWINGS_RST;
            cfg_reg.max_swing_gap <= MAX_GAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ENABLE:     prdata = {{(DATA_BITS-1){1'b0}}, cfg_reg.enable};
            REG_MIN_SWINGS: prdata = {{(DATA_BITS-MINSW_BITS){1'b0}}, cfg_reg.min_swings};
            REG_MAX_GAP:    prdata = {{(DATA_BITS-GAP_BITS){1'b0}}, cfg_reg.max_swing_gap};
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### design/hwg_step.sv
// module: per-frame update of one hand's wave state and event selection
module hwg_step #(
    parameter int SHOULDER_SHIFT = hwg_pkg::SHOULDER_SHIFT_DEF
) (
    input  hwg_pkg::hwg_in_t   item,
    input  hwg_pkg::hwg_cfg_t  cfg,
    input  hwg_pkg::hwg_hand_t hand,
    output hwg_pkg::hwg_hand_t hand_next,
    output logic               emit,
    output hwg_pkg::hwg_out_t  result
);
    import hwg_pkg::*;

    localparam int CB = COORD_BITS;

    logic                  cancel;
    logic                  start;
    logic                  armed;
    logic [COUNT_BITS-1:0] need;
    coord_t                lx_eff;
    side_t                 side_eff;
    logic [TIME_BITS-1:0]  lst_eff;
    logic signed [CB:0]    dx_s;
    logic signed [CB:0]    sh_s;
    logic [CB:0]           dx_mag;
    logic [CB:0]           sh_mag;
    logic [CB:0]           thr;
    logic                  big;
    logic                  go_left;
    logic                  go_right;
    logic                  moved;
    logic [TIME_BITS-1:0]  lst1;
    logic [COUNT_BITS-1:0] cnt1;
    logic [TIME_BITS-1:0]  gap;
    logic                  timeout;
    logic [TIME_BITS-1:0]  lst2;
    logic [COUNT_BITS-1:0] cnt2;
    logic                  done;
    logic                  start_ok;
    logic                  end_ok;

    assign cancel = (item.hand_y < item.elbow_y) || (item.hand_y > item.head_y) ||
                    (item.hand_y < item.hip_y);
    assign start  = !cancel && (item.hand_y > item.hip_y) &&
                    (item.hand_y > item.elbow_y) && !hand.in_position;
    assign armed  = !cancel && (hand.in_position || start);

    // zero min_swings behaves as one
    assign need = (cfg.min_swings == '0) ? COUNT_BITS'(1) : COUNT_BITS'(cfg.min_swings);

    // arming snaps the reference to this frame
    assign lx_eff   = start ? item.hand_x : hand.last_hand_x;
    assign side_eff = start ? SIDE_ORIGIN : hand.swing_side;
    assign lst_eff  = start ? item.time_now : hand.last_swing_time;

    assign dx_s   = {item.hand_x[CB-1], item.hand_x} - {lx_eff[CB-1], lx_eff};
    assign sh_s   = {item.left_shoulder_x[CB-1], item.left_shoulder_x} -
                    {item.right_shoulder_x[CB-1], item.right_shoulder_x};
    assign dx_mag = dx_s[CB] ? (CB+1)'(-dx_s) : (CB+1)'(dx_s);
    assign sh_mag = sh_s[CB] ? (CB+1)'(-sh_s) : (CB+1)'(sh_s);
    assign thr    = sh_mag >> SHOULDER_SHIFT;
    assign big    = dx_mag > thr;

    assign go_left  = item.hand_tracked && (item.hand_x < lx_eff) && big &&
                      (side_eff == SIDE_RIGHT || side_eff == SIDE_ORIGIN);
    assign go_right = item.hand_tracked && (item.hand_x > lx_eff) && big && !go_left &&
                      (side_eff == SIDE_LEFT || side_eff == SIDE_ORIGIN);
    assign moved    = go_left || go_right;

    assign lst1 = moved ? item.time_now : lst_eff;
    assign cnt1 = (moved && hand.swing_count != COUNT_MAX) ? hand.swing_count + 1'b1
                                                           : hand.swing_count;

    assign gap     = item.time_now - lst1;
    assign timeout = gap > TIME_BITS'(cfg.max_swing_gap);
    assign lst2    = timeout ? item.time_now : lst1;
    assign cnt2    = timeout ? '0 : cnt1;
    assign done    = cnt2 == need;

    assign start_ok = hand.last_event != EV_STARTED;
    assign end_ok   = hand.last_event == EV_STARTED;

    always_comb begin
        hand_next         = hand;
        emit              = 1'b0;
        result.event_hand = item.hand_select;
        result.event_step = STEP_STARTED;
        if (cfg.enable) begin
            if (cancel) begin
                hand_next.last_swing_time = '0;
                hand_next.in_position     = 1'b0;
                hand_next.swing_count     = '0;
                if (end_ok) begin
                    hand_next.last_event = EV_CANCELLED;
                    emit                 = 1'b1;
                    result.event_step    = STEP_CANCELLED;
                end
            end else if (armed) begin
                hand_next.in_position     = 1'b1;
                hand_next.swing_side      = go_left ? SIDE_LEFT :
                                            (go_right ? SIDE_RIGHT : side_eff);
                hand_next.last_swing_time = lst2;
                hand_next.swing_count     = done ? cnt2 + 1'b1 : cnt2;
                hand_next.last_hand_x     = item.hand_x;
                if (start && start_ok) begin
                    hand_next.last_event = EV_STARTED;
                    emit                 = 1'b1;
                    result.event_step    = STEP_STARTED;
                end else if (done && end_ok) begin
                    hand_next.last_event = EV_COMPLETED;
                    emit                 = 1'b1;
                    result.event_step    = STEP_COMPLETED;
                end
            end
        end
    end

endmodule

### design/hand_wave_gesture_detector.sv
// top level: hand wave gesture detector with frame input, event output and apb registers
//
// Takes one skeleton frame per transaction on the s_ channel and returns at most one
// event transaction (started, completed or cancelled) on the m_ channel. A frame can be
// accepted in every cycle: it is caught in an input register, and once the result register
// is free a single pass of compare, subtract and count logic reads that hand's state,
// writes it back and loads the result register. The only thing that stops intake is a
// result register still holding an untaken event. Two frames of the same hand in
// consecutive cycles are fine, since the per-hand state is written at the same edge the
// next frame enters the input register.
// Registers (byte address): enable at 0x0, min_swings at 0x4, max_swing_gap at 0x8;
// write them only while no frame is in flight.
module hand_wave_gesture_detector #(
    parameter int SHOULDER_SHIFT = hwg_pkg::SHOULDER_SHIFT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // frame channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  hwg_pkg::hwg_in_t              s_data,
    // event channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output hwg_pkg::hwg_out_t             m_data,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hwg_pkg::ADDR_BITS-1:0] paddr,
    input  logic [hwg_pkg::DATA_BITS-1:0] pwdata,
    output logic [hwg_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);
    import hwg_pkg::*;

    hwg_cfg_t  cfg;

    // input register
    logic      in_valid_reg;
    hwg_in_t   in_data_reg;

    // result register
    logic      out_valid_reg;
    hwg_out_t  out_data_reg;

    // per-hand state, indexed by hand_select
    hwg_hand_t hand_reg [2];

    hwg_hand_t hand_cur;
    hwg_hand_t hand_next;
    logic      emit;
    hwg_out_t  result;
    logic      out_free;
    logic      fire;

    hwg_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // result slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_ready;
    // the held frame is processed whenever its result has somewhere to go
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign hand_cur = hand_reg[in_data_reg.hand_select];

    hwg_step #(
        .SHOULDER_SHIFT (SHOULDER_SHIFT)
    ) u_step (
        .item      (in_data_reg),
        .cfg       (cfg),
        .hand      (hand_cur),
        .hand_next (hand_next),
        .emit      (emit),
        .result    (result)
    );

    // frame capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // hand state write-back, one hand per frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                hand_reg[i].in_position     <= 1'b0;
                hand_reg[i].swing_side      <= SIDE_ORIGIN;
                hand_reg[i].swing_count     <= '0;
                hand_reg[i].last_hand_x     <= '0;
                hand_reg[i].last_swing_time <= '0;
                hand_reg[i].last_event      <= EV_NONE;
            end
        end else if (fire) begin
            hand_reg[in_data_reg.hand_select] <= hand_next;
        end
    end

    // event transaction register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fire && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

### tb/tb_top.sv
// testbench for the hand wave gesture detector: frame stimulus, event prediction and checking
`timescale 1ns / 100ps

module tb_top;
    import hwg_pkg::*;

    // cycles without any accepted transaction before the run is declared hung
    localparam int STALL_LIMIT  = 2000;
    // settling time once the event queue is empty: frames with no event may still be in flight
    localparam int DRAIN_CYCLES = 6;

    // ------------------------------------------------------------------
    // predictor and store of expected events
    // ------------------------------------------------------------------
    class wave_scoreboard;
        hwg_cfg_t  cfg;
        hwg_hand_t hand_st [2];
        hwg_out_t  events_due [$];
        int        errors;

        function new();
            cfg.enable        = 1'b0;
            cfg.min_swings    = MIN_SWINGS_RST;
            cfg.max_swing_gap = MAX_GAP_RST;
            hand_st[0]        = '0;
            hand_st[1]        = '0;
            errors            = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [31:0] val);
            case (idx)
                REG_ENABLE:     cfg.enable        = val[0];
                REG_MIN_SWINGS: cfg.min_swings    = val[MINSW_BITS-1:0];
                REG_MAX_GAP:    cfg.max_swing_gap = val[GAP_BITS-1:0];
                default: ;
            endcase
        endfunction

        // event gating by the last event of the hand; returns 1 when the event goes out
        function bit post_event(input logic h, input event_t ev);
            hwg_out_t o;
            if (ev == EV_STARTED) begin
                if (hand_st[h].last_event == EV_STARTED) return 1'b0;
            end else if (hand_st[h].last_event != EV_STARTED) begin
                return 1'b0;
            end
            hand_st[h].last_event = ev;
            o.event_hand = h;
            case (ev)
                EV_STARTED:   o.event_step = STEP_STARTED;
                EV_COMPLETED: o.event_step = STEP_COMPLETED;
                default:      o.event_step = STEP_CANCELLED;
            endcase
            events_due = {events_due, o};
            return 1'b1;
        endfunction

        function void note_frame(input hwg_in_t f);
            logic                        h;
            logic [COUNT_BITS-1:0]       need;
            bit                          started;
            bit                          moved;
            logic signed [COORD_BITS:0]  dx;
            logic signed [COORD_BITS:0]  span;
            logic signed [COORD_BITS:0]  thr;
            logic [TIME_BITS-1:0]        since;
            if (!cfg.enable) return;
            h       = f.hand_select;
            need    = (cfg.min_swings == '0) ? 5'd1 : {1'b0, cfg.min_swings};
            started = 1'b0;

            // hand out of the waving zone
            if (f.hand_y < f.elbow_y || f.hand_y > f.head_y || f.hand_y < f.hip_y) begin
                hand_st[h].last_swing_time = '0;
                hand_st[h].in_position     = 1'b0;
                hand_st[h].swing_count     = '0;
                void'(post_event(h, EV_CANCELLED));
                return;
            end

            // arming: strictly above elbow and hip
            if (f.hand_y > f.hip_y && f.hand_y > f.elbow_y && !hand_st[h].in_position) begin
                hand_st[h].last_swing_time = f.time_now;
                hand_st[h].in_position     = 1'b1;
                hand_st[h].swing_side      = SIDE_ORIGIN;
                hand_st[h].last_hand_x     = f.hand_x;
                started = post_event(h, EV_STARTED);
            end

            if (hand_st[h].in_position) begin
                if (f.hand_tracked) begin
                    dx = f.hand_x - hand_st[h].last_hand_x;
                    if (dx < 0) dx = -dx;
                    span = f.left_shoulder_x - f.right_shoulder_x;
                    if (span < 0) span = -span;
                    thr   = span >> SHOULDER_SHIFT_DEF;
                    moved = 1'b0;
                    if (f.hand_x < hand_st[h].last_hand_x && dx > thr &&
                        (hand_st[h].swing_side == SIDE_RIGHT ||
                         hand_st[h].swing_side == SIDE_ORIGIN)) begin
                        hand_st[h].swing_side = SIDE_LEFT;
                        moved = 1'b1;
                    end else if (f.hand_x > hand_st[h].last_hand_x && dx > thr &&
                                 (hand_st[h].swing_side == SIDE_LEFT ||
                                  hand_st[h].swing_side == SIDE_ORIGIN)) begin
                        hand_st[h].swing_side = SIDE_RIGHT;
                        moved = 1'b1;
                    end
                    if (moved) begin
                        hand_st[h].last_swing_time = f.time_now;
                        if (hand_st[h].swing_count < COUNT_MAX)
                            hand_st[h].swing_count = hand_st[h].swing_count + 1'b1;
                    end
                end

                since = f.time_now - hand_st[h].last_swing_time;
                if (since > cfg.max_swing_gap) begin
                    hand_st[h].last_swing_time = f.time_now;
                    hand_st[h].swing_count     = '0;
                end

                if (hand_st[h].swing_count == need) begin
                    hand_st[h].swing_count = hand_st[h].swing_count + 1'b1;
                    if (!started) void'(post_event(h, EV_COMPLETED));
                end

                hand_st[h].last_hand_x = f.hand_x;
            end
        endfunction

        function void check_event(input hwg_out_t got);
            hwg_out_t want;
            if (events_due.size() == 0) begin
                $error("unexpected event: event_hand %0d event_step %0d",
                       got.event_hand, got.event_step);
                errors++;
                return;
            end
            want = events_due.pop_front();
            if (got.event_hand !== want.event_hand) begin
                $error("event_hand: expected %0d, actual %0d", want.event_hand, got.event_hand);
                errors++;
            end
            if (got.event_step !== want.event_step) begin
                $error("event_step: expected %0d, actual %0d", want.event_step, got.event_step);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // signals and the block
    // ------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    hwg_in_t              s_data;
    logic                 m_valid;
    logic                 m_ready;
    hwg_out_t             m_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    wave_scoreboard board = new();

    // idle rates in percent per cycle, changed between phases
    int send_idle;
    int recv_idle;
    int stall_cycles;

    // per-hand trajectory used to build well-formed waves
    bit                   wave_dir [2];
    int                   wave_x   [2];
    logic [TIME_BITS-1:0] wave_t   [2];

    // settings per random phase: extremes of min_swings and max_swing_gap, a disabled phase
    int phase_items  [6] = '{400, 350, 450, 250, 100, 400};
    int phase_enable [6] = '{1, 1, 1, 1, 0, 1};
    int phase_min    [6] = '{6, 1, 15, 0, 9, 3};
    int phase_gap    [6] = '{200, 65535, 1000, 0, 50, 1};

    hand_wave_gesture_detector uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random back-pressure on the event channel
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // every accepted event transaction is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_event(m_data);
    end

    // watchdog: counts cycles in which neither channel moves a transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // frame building
    // ------------------------------------------------------------------
    function automatic hwg_in_t mk_frame(input logic h, input int x, input int y,
                                         input logic trk, input int elbow, input int hip,
                                         input int head, input int lsx, input int rsx,
                                         input logic [TIME_BITS-1:0] t);
        hwg_in_t f;
        f.hand_select      = h;
        f.hand_x           = coord_t'(x);
        f.hand_y           = coord_t'(y);
        f.hand_tracked     = trk;
        f.elbow_y          = coord_t'(elbow);
        f.hip_y            = coord_t'(hip);
        f.head_y           = coord_t'(head);
        f.left_shoulder_x  = coord_t'(lsx);
        f.right_shoulder_x = coord_t'(rsx);
        f.time_now         = t;
        return f;
    endfunction

    // mostly plausible waving frames, with some broken poses, stalls and pure noise
    function automatic hwg_in_t wave_frame(input logic [GAP_BITS-1:0] gap);
        logic [191:0]         noise;
        logic                 h;
        int                   roll;
        int                   elbow;
        int                   hip;
        int                   head;
        int                   lsx;
        int                   rsx;
        int                   span;
        int                   thr;
        int                   floor_y;
        int                   y;
        int                   x;
        int                   amp;
        logic [TIME_BITS-1:0] dt;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return noise[$bits(hwg_in_t)-1:0];
        end
        h     = 1'($urandom_range(0, 1));
        elbow = -int'($urandom_range(0, 3000));
        hip   = -int'($urandom_range(500, 5000));
        head  = $urandom_range(1000, 6000);
        lsx   = -int'($urandom_range(50, 2000));
        rsx   = $urandom_range(50, 2000);
        if ($urandom_range(0, 1)) begin
            lsx = -lsx;
            rsx = -rsx;
        end
        span = rsx - lsx;
        if (span < 0) span = -span;
        thr     = span >> SHOULDER_SHIFT_DEF;
        floor_y = (elbow > hip) ? elbow : hip;

        // pose: below the elbow or hip, above the head, level, or in the waving zone
        if (roll < 9)
            y = floor_y - 1 - int'($urandom_range(0, 2000));
        else if (roll < 11)
            y = head + 1 + int'($urandom_range(0, 2000));
        else if (roll < 15)
            y = $urandom_range(0, 1) ? elbow : hip;
        else
            y = floor_y + 1 + int'($urandom_range(0, head - floor_y - 1));

        // swing: a reversal past the threshold, or a small drift that must not count
        if ($urandom_range(0, 99) < 85) begin
            wave_dir[h] = !wave_dir[h];
            amp = thr / 2 + 1 + int'($urandom_range(0, 300));
            x   = wave_dir[h] ? amp : -amp;
        end else begin
            x = wave_x[h] + int'($urandom_range(0, thr)) - thr / 2;
        end
        wave_x[h] = x;

        // timestamp: mostly inside the swing gap, sometimes past it, now and then a jump
        roll = $urandom_range(0, 99);
        if (roll < 85)
            dt = $urandom_range(0, gap / 2);
        else if (roll < 93)
            dt = $urandom_range(0, gap);
        else if (roll < 97)
            dt = gap + 1 + $urandom_range(0, 50);
        else
            dt = $urandom;
        wave_t[h] = wave_t[h] + dt;

        return mk_frame(h, x, y, $urandom_range(0, 99) < 92, elbow, hip, head, lsx, rsx,
                        wave_t[h]);
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // one frame transaction; returns at the edge where it is accepted
    task automatic send_frame(input hwg_in_t f);
        int gap_cycles;
        gap_cycles = 0;
        while ($urandom_range(0, 99) < send_idle) gap_cycles++;
        if (gap_cycles > 0) begin
            s_valid <= 1'b0;
            repeat (gap_cycles) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= f;
        do @(posedge aclk); while (!s_ready);
        board.note_frame(f);
    endtask

    // apb write: setup phase, access phase, then a quiet phase
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // hold the sender until every predicted event has arrived, then let the pipe settle
    task automatic drain_events();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.events_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        s_valid      <= 1'b0;
        s_data       <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        m_ready      <= 1'b0;
        aresetn      <= 1'b0;
        stall_cycles <= 0;
        send_idle     = 9;
        recv_idle     = 64;
        wave_dir      = '{1'b0, 1'b0};
        wave_x        = '{0, 0};
        wave_t        = '{32'd0, 32'd0};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part: two swings complete a wave
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_MIN_SWINGS, 32'd2);
        write_reg(REG_MAX_GAP, 32'd200);

        // left hand: arm, swing to completion, level with elbow, untracked with gap timeout
        send_frame(mk_frame(1'b0,    0,    0, 1'b1, -100, -500, 1000, -400, 400, 32'd1000));
        send_frame(mk_frame(1'b0, -200,    0, 1'b1, -100, -500, 1000, -400, 400, 32'd1050));
        send_frame(mk_frame(1'b0,   50,    0, 1'b1, -100, -500, 1000, -400, 400, 32'd1100));
        send_frame(mk_frame(1'b0, -300,    0, 1'b1, -100, -500, 1000, -400, 400, 32'd1150));
        send_frame(mk_frame(1'b0,  100, -100, 1'b1, -100, -500, 1000, -400, 400, 32'd1200));
        send_frame(mk_frame(1'b0, -400,    0, 1'b0, -100, -500, 1000, -400, 400, 32'd1500));
        // below the hip after a completion: the cancel is gated off
        send_frame(mk_frame(1'b0,    0, -600, 1'b1, -100, -500, 1000, -400, 400, 32'd1550));
        send_frame(mk_frame(1'b0,    0,    0, 1'b1, -100, -500, 1000, -400, 400, 32'd1600));
        // above the head while armed: cancel goes out
        send_frame(mk_frame(1'b0,    0, 2000, 1'b1, -100, -500, 1000, -400, 400, 32'd1650));
        // level with the elbow while not armed: nothing
        send_frame(mk_frame(1'b0,    0, -100, 1'b1, -100, -500, 1000, -400, 400, 32'd1700));

        // right hand: full-scale x and shoulders, timestamp wrapping through zero
        send_frame(mk_frame(1'b1,  32767, 0, 1'b1, -100, -500, 1000, -32768, 32767,
                            32'hFFFF_FFF0));
        send_frame(mk_frame(1'b1, -32768, 0, 1'b1, -100, -500, 1000, -32768, 32767,
                            32'h0000_0010));
        send_frame(mk_frame(1'b1, -32768, 0, 1'b1, -100, -500, 1000, -32768, 32767,
                            32'h0000_0020));
        send_frame(mk_frame(1'b1,  32767, 0, 1'b1, -100, -500, 1000, -32768, 32767,
                            32'h0000_0030));
        send_frame(mk_frame(1'b1,      0, 0, 1'b1, -100, -500, 1000, -32768, 32767,
                            32'h0000_0040));
        send_frame(mk_frame(1'b1, 0, -32768, 1'b1, -100, -500, 1000, 0, 0, 32'h0000_0050));
        // extreme heights: hand level with the head arms, level with elbow and hip keeps swinging
        send_frame(mk_frame(1'b1, -32768, 32767, 1'b1, -32768, -32768, 32767, 32767, -32768,
                            32'hFFFF_FFFF));
        send_frame(mk_frame(1'b1, 0, -32768, 1'b1, -32768, -32768, 32767, 0, 0, 32'd0));
        send_frame(mk_frame(1'b0, 5, 7, 1'b1, 7, 7, 7, 3, 3, 32'd1750));
        send_frame(mk_frame(1'b1, 0, -32768, 1'b1, -32767, 0, 32767, 0, 0, 32'd1));

        // random phases, each with its own register setting and idle pattern
        for (int p = 0; p < 6; p++) begin
            drain_events();
            if (p < 2) begin
                send_idle = 9;
                recv_idle = 64;
            end else if (p < 4) begin
                send_idle = 64;
                recv_idle = 9;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_reg(REG_ENABLE, phase_enable[p]);
            write_reg(REG_MIN_SWINGS, phase_min[p]);
            write_reg(REG_MAX_GAP, phase_gap[p]);
            wave_t[0] = $urandom;
            wave_t[1] = $urandom;
            for (int i = 0; i < phase_items[p]; i++) begin
                // now and then the sender waits for the event channel to run dry
                if (i > 0 && i % 150 == 0) drain_events();
                send_frame(wave_frame(GAP_BITS'(phase_gap[p])));
            end
        end

        drain_events();
        if (board.events_due.size() != 0) begin
            $error("%0d predicted events never arrived", board.events_due.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
